// ===== rtl/mbsp_pkg.sv =====
// Shared types, byte-class constants and decode helpers for the MIDI byte stream parser.
// No dependencies.
package mbsp_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned DATA_W = 7;

    localparam logic [BYTE_W-1:0] STATUS_BIT     = 8'h80;
    localparam logic [BYTE_W-1:0] SYSTEM_BASE    = 8'hF0;
    localparam logic [BYTE_W-1:0] REALTIME_BASE  = 8'hF8;
    localparam logic [3:0]        TYPE_PROGRAM   = 4'hC;
    localparam logic [3:0]        TYPE_CHAN_PRES = 4'hD;
    localparam logic [BYTE_W-1:0] NO_STATUS      = 8'h00;

    // Result item, status in the low bits.
    typedef struct packed {
        logic [DATA_W-1:0] data_second;
        logic [DATA_W-1:0] data_first;
        logic [BYTE_W-1:0] status;
    } t_msg;

    localparam int unsigned MSG_W   = $bits(t_msg);
    localparam int unsigned TDATA_W = ((MSG_W + 7) / 8) * 8;

    // Program change and channel pressure carry a single data byte.
    function automatic logic f_is_short(input logic [BYTE_W-1:0] status);
        logic [3:0] kind;
        kind = status[BYTE_W-1 -: 4];
        return (kind == TYPE_PROGRAM) || (kind == TYPE_CHAN_PRES);
    endfunction

endpackage

// ===== rtl/midi_byte_stream_parser_unit.sv =====
// MIDI byte stream parser: input register, running-status decode, result register.
// Depends on mbsp_pkg.
//
// Takes one serial MIDI byte per item and sends out assembled channel voice messages,
// and real-time bytes (F8-FF) at once as one-byte messages. The unit accepts a byte in
// every clock cycle while the result side does not stall; a result is valid once its last
// byte has passed through the input register and its decode is loaded into the result
// register. That rate comes from the decode being a single pass of a few compares
// against the running status. Stalls on the result side back up into the input
// register and then into s_axis_tready. System common/exclusive bytes cancel running
// status; data bytes without a running status are dropped. Unused data fields read 0.
module midi_byte_stream_parser_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [mbsp_pkg::BYTE_W-1:0]   s_axis_tdata,   // [7:0] rx_byte
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [mbsp_pkg::TDATA_W-1:0]  m_axis_tdata    // [7:0] msg_status,
                                                          // [14:8] msg_data_first,
                                                          // [21:15] msg_data_second
);
    import mbsp_pkg::*;

    // input register
    logic              r_in_vld;
    logic [BYTE_W-1:0] r_in_byte;

    // parse state
    logic [BYTE_W-1:0] r_run_status, n_run_status;
    logic              r_have_first, n_have_first;
    logic [DATA_W-1:0] r_held_first, n_held_first;

    // result register
    logic              r_out_vld;
    t_msg              r_out_msg;

    logic              go;
    logic              emit;
    t_msg              n_msg;

    assign go            = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || go;

    always_comb begin
        n_run_status = r_run_status;
        n_have_first = r_have_first;
        n_held_first = r_held_first;
        emit         = 1'b0;
        n_msg        = '{data_second: '0, data_first: '0, status: r_run_status};

        if ((r_in_byte & STATUS_BIT) != '0) begin
            if (r_in_byte >= REALTIME_BASE) begin
                emit         = 1'b1;
                n_msg.status = r_in_byte;
            end else begin
                n_run_status = (r_in_byte >= SYSTEM_BASE) ? NO_STATUS : r_in_byte;
                n_have_first = 1'b0;
                n_held_first = '0;
            end
        end else if (r_run_status != NO_STATUS) begin
            if (f_is_short(r_run_status)) begin
                emit             = 1'b1;
                n_have_first     = 1'b0;
                n_msg.data_first = r_in_byte[DATA_W-1:0];
            end else if (!r_have_first) begin
                n_have_first = 1'b1;
                n_held_first = r_in_byte[DATA_W-1:0];
            end else begin
                emit              = 1'b1;
                n_have_first      = 1'b0;
                n_msg.data_first  = r_held_first;
                n_msg.data_second = r_in_byte[DATA_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
            r_run_status <= NO_STATUS;
            r_have_first <= 1'b0;
            r_held_first <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_vld <= s_axis_tvalid;
            end
            if (go) begin
                r_out_vld    <= emit;
                r_run_status <= n_run_status;
                r_have_first <= n_have_first;
                r_held_first <= n_held_first;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
        if (go && emit) begin
            r_out_msg <= n_msg;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{(TDATA_W-MSG_W){1'b0}}, r_out_msg};

endmodule
